// ===== rtl/smsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smsl_pkg
// Shared types, codes and sizes of the sorted multiset list unit.
// ----------------------------------------------------------------------------
package smsl_pkg;

    localparam int CAPACITY  = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LIST   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_INS_WR,
        S_REM_CMP,
        S_LST_OUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] n);
        logic [CNT_W+COUNT_W-1:0] t;
        t = {{COUNT_W{1'b0}}, n};
        return t[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/smsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smsl_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smsl_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smsl_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smsl_cmp
// Shared signed compare unit: greater-than and equality of two values.
// ----------------------------------------------------------------------------
module smsl_cmp (
    input  wire logic [smsl_pkg::DATA_W-1:0] a,
    input  wire logic [smsl_pkg::DATA_W-1:0] b,
    output smsl_pkg::cmp_res_t               res
);

    always_comb
    begin
        res.gt = $signed(a) > $signed(b);
        res.eq = (a == b);
    end

endmodule
`default_nettype wire

// ===== rtl/sorted_multiset_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_list_unit
// Sorted multiset of signed values with insert, remove-all, list and clear.
//
//   channel   dir  tdata                       tuser        tlast
//   s_axis    in   value[31:0]                 func[1:0]    -
//   m_axis    out  element[31:0], count[37:32] status[2:0]  last
//
// One item at a time; s_axis_tready is high only while the sequencer idles.
// Insert shifts every entry greater than the value up one place and writes it
// into the gap; a full store answers ST_FULL. Remove reads every stored entry
// and compacts the kept ones down. Clear empties the store. Remove and list on
// an empty store answer ST_EMPTY. List emits every entry in order; every result
// waits on m_axis_tready. Entries go one by one through the single read port and
// the one shared comparator. Reset empties the store at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_multiset_list_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // element[31:0], count[37:32], zero
    output logic      [2:0]  m_axis_tuser,   // status[2:0]
    output logic             m_axis_tlast
);

    localparam int AW = smsl_pkg::ADDR_W;
    localparam int CW = smsl_pkg::CNT_W;
    localparam int DW = smsl_pkg::DATA_W;

    smsl_pkg::state_t state_reg, state_next;

    logic [smsl_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [DW-1:0]                 value_reg, value_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 kept_reg, kept_next;
    logic [smsl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [smsl_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [smsl_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DW-1:0]                 out_element_reg, out_element_next;
    logic [smsl_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    smsl_pkg::cmp_res_t cmp_res;

    logic          out_free;
    logic [CW-1:0] occ_m1;
    logic [CW-1:0] occ_p1;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_m2;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] kept_new;
    logic [CW-1:0] removed;

    smsl_ram #(
        .DEPTH (smsl_pkg::CAPACITY),
        .WIDTH (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smsl_cmp u_cmp (
        .a   (rd_data),
        .b   (value_reg),
        .res (cmp_res)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign occ_m1   = occ_reg - CW'(1);
    assign occ_p1   = occ_reg + CW'(1);
    assign idx_m1   = idx_reg - CW'(1);
    assign idx_m2   = idx_reg - CW'(2);
    assign idx_p1   = idx_reg + CW'(1);
    assign kept_new = kept_reg + CW'(!cmp_res.eq);
    assign removed  = occ_reg - kept_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smsl_pkg::S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        value_reg       <= value_next;
        idx_reg         <= idx_next;
        kept_reg        <= kept_next;
        res_status_reg  <= res_status_next;
        res_count_reg   <= res_count_next;
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        value_next       = value_reg;
        occ_next         = occ_reg;
        idx_next         = idx_reg;
        kept_next        = kept_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg[AW-1:0];
        wr_data          = rd_data;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[AW-1:0];
        s_axis_tready    = 1'b0;

        unique case (state_reg)
            smsl_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    func_next  = s_axis_tuser;
                    value_next = s_axis_tdata;
                    state_next = smsl_pkg::S_DISPATCH;
                end
            end

            smsl_pkg::S_DISPATCH:
            begin
                idx_next  = '0;
                kept_next = '0;
                unique case (func_reg)
                    smsl_pkg::FN_INSERT:
                    begin
                        if (occ_reg >= CW'(smsl_pkg::CAPACITY))
                        begin
                            res_status_next = smsl_pkg::ST_FULL;
                            res_count_next  = smsl_pkg::to_count(occ_reg);
                            state_next      = smsl_pkg::S_EMIT;
                        end
                        else if (occ_reg == '0)
                        begin
                            state_next = smsl_pkg::S_INS_WR;
                        end
                        else
                        begin
                            idx_next   = occ_reg;
                            rd_en      = 1'b1;
                            rd_addr    = occ_m1[AW-1:0];
                            state_next = smsl_pkg::S_INS_CMP;
                        end
                    end
                    smsl_pkg::FN_REMOVE,
                    smsl_pkg::FN_LIST:
                    begin
                        if (occ_reg == '0)
                        begin
                            res_status_next = smsl_pkg::ST_EMPTY;
                            res_count_next  = '0;
                            state_next      = smsl_pkg::S_EMIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = (func_reg == smsl_pkg::FN_LIST) ?
                                         smsl_pkg::S_LST_OUT : smsl_pkg::S_REM_CMP;
                        end
                    end
                    smsl_pkg::FN_CLEAR:
                    begin
                        res_status_next = (occ_reg == '0) ? smsl_pkg::ST_EMPTY
                                                          : smsl_pkg::ST_CLEARED;
                        res_count_next  = '0;
                        occ_next        = '0;
                        state_next      = smsl_pkg::S_EMIT;
                    end
                    default:
                    begin
                        state_next = smsl_pkg::S_IDLE;
                    end
                endcase
            end

            smsl_pkg::S_INS_CMP:
            begin
                if (cmp_res.gt)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_m1;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = smsl_pkg::S_INS_WR;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_m2[AW-1:0];
                    end
                end
                else
                begin
                    state_next = smsl_pkg::S_INS_WR;
                end
            end

            smsl_pkg::S_INS_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = idx_reg[AW-1:0];
                wr_data         = value_reg;
                occ_next        = occ_p1;
                res_status_next = smsl_pkg::ST_INSERTED;
                res_count_next  = smsl_pkg::to_count(occ_p1);
                state_next      = smsl_pkg::S_EMIT;
            end

            smsl_pkg::S_REM_CMP:
            begin
                // keep the entry: compact it down behind the read pointer
                if (!cmp_res.eq)
                begin
                    wr_en   = 1'b1;
                    wr_addr = kept_reg[AW-1:0];
                    wr_data = rd_data;
                end
                kept_next = kept_new;
                idx_next  = idx_p1;
                if (idx_p1 == occ_reg)
                begin
                    occ_next = kept_new;
                    if (removed == '0)
                    begin
                        res_status_next = smsl_pkg::ST_NOTFOUND;
                        res_count_next  = '0;
                    end
                    else
                    begin
                        res_status_next = smsl_pkg::ST_REMOVED;
                        res_count_next  = smsl_pkg::to_count(removed);
                    end
                    state_next = smsl_pkg::S_EMIT;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p1[AW-1:0];
                end
            end

            smsl_pkg::S_LST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = smsl_pkg::ST_LISTED;
                    out_element_next = rd_data;
                    out_count_next   = smsl_pkg::to_count(occ_reg);
                    out_last_next    = (idx_p1 == occ_reg);
                    idx_next         = idx_p1;
                    if (idx_p1 == occ_reg)
                    begin
                        state_next = smsl_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_p1[AW-1:0];
                    end
                end
            end

            smsl_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_element_next = '0;
                    out_count_next   = res_count_reg;
                    out_last_next    = 1'b1;
                    state_next       = smsl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = smsl_pkg::S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_element_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(smsl_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_ins_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smsl_pkg::S_INS_CMP |-> idx_reg != '0 && idx_reg <= occ_reg)
        else $error("insert shift pointer out of range");

    a_rem_kept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smsl_pkg::S_REM_CMP |-> kept_reg <= idx_reg && idx_reg < occ_reg)
        else $error("remove compaction overtook read pointer");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != smsl_pkg::ST_LISTED |-> out_last_reg)
        else $error("single result without last");

    a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smsl_pkg::S_LST_OUT && out_free && idx_p1 == occ_reg
        |=> state_reg == smsl_pkg::S_IDLE && out_valid_reg && out_last_reg)
        else $error("listing did not close with last");
`endif

endmodule
`default_nettype wire
